// File: src/categorical_naive_bayes_classifier_defines.svh
// assertion macros for the categorical naive bayes classifier
// no dependencies; included by the modules that carry assertions
`ifndef CATEGORICAL_NAIVE_BAYES_CLASSIFIER_DEFINES_SVH
`define CATEGORICAL_NAIVE_BAYES_CLASSIFIER_DEFINES_SVH
`ifndef SYNTH
`define CNB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CNB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CNB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CNB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/cnb_pkg.sv
// types, constants and helpers for the categorical naive bayes classifier
// no dependencies
package cnb_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int NUM_CELLS     = 9;
    localparam int NUM_SYMS      = 3;
    localparam int NUM_CLASSES   = 2;
    localparam int DEPTH         = NUM_CELLS * NUM_CLASSES * NUM_SYMS;
    localparam int ADDR_BITS     = $clog2(DEPTH);
    localparam int POS_BITS      = $clog2(NUM_CELLS);
    localparam int FACTOR_BITS   = COUNT_BITS + 1;
    localparam int LIMB_BITS     = 32;
    localparam int PROD_BITS     = LIMB_BITS + FACTOR_BITS;
    localparam int SCORE_BITS    = COUNT_BITS + 2 * NUM_CELLS * FACTOR_BITS;
    localparam int LIMBS         = (SCORE_BITS + LIMB_BITS - 1) / LIMB_BITS;
    localparam int LIMB_CNT_BITS = $clog2(LIMBS);
    localparam int TDATA_IN_BITS = 24;
    localparam int TDATA_OUT_BITS = 8;

    localparam logic [COUNT_BITS:0] COUNT_LIMIT = (COUNT_BITS+1)'((1 << COUNT_BITS) - 1);

    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [1:0]            t_sym;

    localparam t_sym SYM_BLANK = 2'd0;
    localparam t_sym SYM_X     = 2'd1;
    localparam t_sym SYM_O     = 2'd2;

    typedef enum logic [1:0] {
        MODE_CLEAR    = 2'd0,
        MODE_TRAIN    = 2'd1,
        MODE_CLASSIFY = 2'd2,
        MODE_NONE     = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRAIN,
        S_CRD,
        S_CMUL,
        S_CMP,
        S_DONE
    } t_state;

    function automatic t_sym sym_of(input logic [1:0] code);
        t_sym s;
        s = SYM_BLANK;
        if (code == SYM_X || code == SYM_O) begin
            s = code;
        end
        return s;
    endfunction

    function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [POS_BITS-1:0] pos,
                                                     input logic cls,
                                                     input t_sym sym);
        int a;
        a = int'(pos) * NUM_CLASSES * NUM_SYMS + int'(cls) * NUM_SYMS + int'(sym);
        return ADDR_BITS'(a);
    endfunction

endpackage

// File: src/categorical_naive_bayes_classifier.sv
// Two-class naive bayes over nine three-valued board positions with laplace
// smoothing. Mode clear (tuser 0) zeroes all counts, train (1) adds the board
// to its label's counts and is refused with accepted 0 once the total reaches
// 2^COUNT_BITS-1, classify (2) answers 1 only when P*prod(cp+1)*(N+3)^9 is
// strictly above N*prod(cn+1)*(P+3)^9; mode 3 answers 0,0. One item at a time:
// train does nine read-modify-writes on the count memory, and classify walks
// the score limb by limb through the 32x17 multiplier.
// Depends on cnb_pkg and categorical_naive_bayes_classifier_defines.svh.
`include "categorical_naive_bayes_classifier_defines.svh"

module categorical_naive_bayes_classifier
    import cnb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // cell_0..cell_8 (2 bits each), label, zero fill
    input  logic [TDATA_IN_BITS-1:0]  i_s_tdata,
    // mode
    input  logic [1:0]                i_s_tuser,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // predicted_class, accepted, zero fill
    output logic [TDATA_OUT_BITS-1:0] o_m_tdata
);

    t_state r_state, n_state;
    logic   r_label;
    t_sym   r_cells [NUM_CELLS];
    logic [POS_BITS-1:0]      r_pos;
    logic                     r_phase;
    logic [LIMB_CNT_BITS-1:0] r_limb;
    logic [LIMB_BITS-1:0]     r_acc_p [LIMBS];
    logic [LIMB_BITS-1:0]     r_acc_n [LIMBS];
    logic [FACTOR_BITS-1:0]   r_carry_p, r_carry_n;
    logic                     r_gt;
    logic                     r_res_pred, r_res_ok;
    t_cnt                     r_pos_total, r_neg_total;
    logic                     r_out_valid;
    logic [1:0]               r_out_data;

    t_cnt             mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_cnt             r_rd_a, r_rd_b;
    logic             r_va, r_vb;
    logic             r_wr_pend;
    logic [ADDR_BITS-1:0] r_wr_addr;

    logic                 s_acc;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr_a, rd_addr_b;
    logic                 out_load;
    t_cnt                 cnt_a, cnt_b;
    logic [FACTOR_BITS-1:0] f_p, f_n;
    logic [PROD_BITS-1:0]   t_p, t_n;
    logic [COUNT_BITS:0]    total;
    logic                   at_limit;
    logic                   limb_last;

    assign s_acc     = i_s_tvalid & o_s_tready;
    assign total     = {1'b0, r_pos_total} + {1'b0, r_neg_total};
    assign at_limit  = (total == COUNT_LIMIT);
    assign limb_last = (r_limb == LIMB_CNT_BITS'(LIMBS - 1));
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    assign cnt_a = r_va ? r_rd_a : '0;
    assign cnt_b = r_vb ? r_rd_b : '0;
    assign f_p = r_phase ? FACTOR_BITS'(r_neg_total) + FACTOR_BITS'(3)
                         : FACTOR_BITS'(cnt_a) + FACTOR_BITS'(1);
    assign f_n = r_phase ? FACTOR_BITS'(r_pos_total) + FACTOR_BITS'(3)
                         : FACTOR_BITS'(cnt_b) + FACTOR_BITS'(1);
    assign t_p = PROD_BITS'(r_acc_p[0]) * PROD_BITS'(f_p)
               + PROD_BITS'((r_limb == '0) ? '0 : r_carry_p);
    assign t_n = PROD_BITS'(r_acc_n[0]) * PROD_BITS'(f_n)
               + PROD_BITS'((r_limb == '0) ? '0 : r_carry_n);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    case (t_mode'(i_s_tuser))
                        MODE_TRAIN:    n_state = at_limit ? S_DONE : S_TRAIN;
                        MODE_CLASSIFY: n_state = S_CRD;
                        default:       n_state = S_DONE;
                    endcase
                end
            end
            S_TRAIN: begin
                if (r_pos == POS_BITS'(NUM_CELLS - 1)) n_state = S_DONE;
            end
            S_CRD: n_state = S_CMUL;
            S_CMUL: begin
                if (limb_last && r_phase) begin
                    n_state = (r_pos == POS_BITS'(NUM_CELLS - 1)) ? S_CMP : S_CRD;
                end
            end
            S_CMP: begin
                if (limb_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and memory control
    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        rd_en      = (r_state == S_TRAIN) || (r_state == S_CRD);
        rd_addr_a  = cell_addr(r_pos, (r_state == S_TRAIN) ? r_label : 1'b1, r_cells[r_pos]);
        rd_addr_b  = cell_addr(r_pos, 1'b0, r_cells[r_pos]);
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(TDATA_OUT_BITS-2){1'b0}}, r_out_data[1], r_out_data[0]};

    // count memory, invalid entries read as zero
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_a <= mem[rd_addr_a];
            r_rd_b <= mem[rd_addr_b];
            r_va   <= r_valid[rd_addr_a];
            r_vb   <= r_valid[rd_addr_b];
        end
        if (r_wr_pend) begin
            mem[r_wr_addr] <= cnt_a + t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= (r_state == S_TRAIN);
            if (s_acc && t_mode'(i_s_tuser) == MODE_CLEAR) begin
                r_valid <= '0;
            end else if (r_wr_pend) begin
                r_valid[r_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_TRAIN) r_wr_addr <= rd_addr_a;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos_total <= '0;
            r_neg_total <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                case (t_mode'(i_s_tuser))
                    MODE_CLEAR: begin
                        r_pos_total <= '0;
                        r_neg_total <= '0;
                    end
                    MODE_TRAIN: begin
                        if (!at_limit) begin
                            if (i_s_tdata[2*NUM_CELLS]) r_pos_total <= r_pos_total + t_cnt'(1);
                            else                        r_neg_total <= r_neg_total + t_cnt'(1);
                        end
                    end
                    default: ;
                endcase
            end
            if (out_load)        r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (out_load) r_out_data <= {r_res_ok, r_res_pred};
        case (r_state)
            S_IDLE: begin
                r_label <= i_s_tdata[2*NUM_CELLS];
                for (int i = 0; i < NUM_CELLS; i++) begin
                    r_cells[i] <= sym_of(i_s_tdata[2*i +: 2]);
                end
                r_pos   <= '0;
                r_phase <= 1'b0;
                r_limb  <= '0;
                r_gt    <= 1'b0;
                for (int i = 0; i < LIMBS; i++) begin
                    r_acc_p[i] <= '0;
                    r_acc_n[i] <= '0;
                end
                r_acc_p[0] <= LIMB_BITS'(r_pos_total);
                r_acc_n[0] <= LIMB_BITS'(r_neg_total);
                r_res_pred <= 1'b0;
                case (t_mode'(i_s_tuser))
                    MODE_CLEAR, MODE_CLASSIFY: r_res_ok <= 1'b1;
                    MODE_TRAIN:                r_res_ok <= !at_limit;
                    default:                   r_res_ok <= 1'b0;
                endcase
            end
            S_TRAIN: r_pos <= r_pos + POS_BITS'(1);
            S_CMUL: begin
                for (int i = 0; i < LIMBS - 1; i++) begin
                    r_acc_p[i] <= r_acc_p[i+1];
                    r_acc_n[i] <= r_acc_n[i+1];
                end
                r_acc_p[LIMBS-1] <= t_p[LIMB_BITS-1:0];
                r_acc_n[LIMBS-1] <= t_n[LIMB_BITS-1:0];
                r_carry_p <= t_p[PROD_BITS-1:LIMB_BITS];
                r_carry_n <= t_n[PROD_BITS-1:LIMB_BITS];
                if (limb_last) begin
                    r_limb  <= '0;
                    r_phase <= !r_phase;
                    if (r_phase) r_pos <= r_pos + POS_BITS'(1);
                end else begin
                    r_limb <= r_limb + LIMB_CNT_BITS'(1);
                end
            end
            S_CMP: begin
                for (int i = 0; i < LIMBS - 1; i++) begin
                    r_acc_p[i] <= r_acc_p[i+1];
                    r_acc_n[i] <= r_acc_n[i+1];
                end
                r_acc_p[LIMBS-1] <= r_acc_p[0];
                r_acc_n[LIMBS-1] <= r_acc_n[0];
                if (r_acc_p[0] != r_acc_n[0]) begin
                    r_gt <= (r_acc_p[0] > r_acc_n[0]);
                end
                if (limb_last) begin
                    r_limb     <= '0;
                    r_res_pred <= (r_acc_p[0] != r_acc_n[0]) ? (r_acc_p[0] > r_acc_n[0]) : r_gt;
                end else begin
                    r_limb <= r_limb + LIMB_CNT_BITS'(1);
                end
            end
            default: ;
        endcase
    end

    `CNB_ASSERT_IMPL(a_no_rmw_overlap, i_clk, i_rst_n, r_wr_pend && rd_en, r_wr_addr != rd_addr_a)
    `CNB_ASSERT_IMPL(a_total_in_range, i_clk, i_rst_n, 1'b1, total <= COUNT_LIMIT)
    `CNB_ASSERT_NEXT(a_clear_zeroes, i_clk, i_rst_n, s_acc && i_s_tuser == MODE_CLEAR, r_pos_total == '0 && r_neg_total == '0 && r_valid == '0)
    `CNB_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, out_load, r_out_valid && r_state == S_IDLE)

endmodule

// File: bench/categorical_naive_bayes_classifier_tb.sv
// testbench for categorical_naive_bayes_classifier: streams clear, train and classify
// requests, predicts each answer with an exact big-number score model, checks in order
// depends on cnb_pkg and the classifier rtl
`timescale 1ns / 100ps

module categorical_naive_bayes_classifier_tb;
    import cnb_pkg::*;

    typedef struct packed {
        logic predicted;
        logic accepted;
    } t_answer;

    typedef logic [1:0] t_board [NUM_CELLS];

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_tvalid;
    logic                      o_s_tready;
    logic [TDATA_IN_BITS-1:0]  i_s_tdata;
    logic [1:0]                i_s_tuser;
    logic                      o_m_tvalid;
    logic                      i_m_tready;
    logic [TDATA_OUT_BITS-1:0] o_m_tdata;

    categorical_naive_bayes_classifier i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // model state
    logic [31:0] pos_total;
    logic [31:0] neg_total;
    logic [31:0] sym_count [DEPTH];

    t_answer answer_q [$];
    int      fail_count;
    int      hold_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("categorical_naive_bayes_classifier_tb: errors");
        $finish;
    end

    function automatic int sym_index(logic [1:0] code);
        return (code == 2'd1 || code == 2'd2) ? int'(code) : 0;
    endfunction

    function automatic logic [511:0] class_score(t_board b, int cls,
                                                 logic [31:0] own, logic [31:0] other);
        logic [511:0] acc;
        acc = 512'(own);
        for (int p = 0; p < NUM_CELLS; p++) begin
            acc = acc * (sym_count[p*6 + cls*3 + sym_index(b[p])] + 1);
            acc = acc * (other + 3);
        end
        return acc;
    endfunction

    function automatic t_answer predict_answer(logic [1:0] mode, t_board b, logic label);
        t_answer a;
        a = '0;
        case (mode)
            MODE_CLEAR: begin
                pos_total = 0;
                neg_total = 0;
                foreach (sym_count[k]) sym_count[k] = 0;
                a.accepted = 1'b1;
            end
            MODE_TRAIN: begin
                if (pos_total + neg_total < COUNT_LIMIT) begin
                    if (label) pos_total++;
                    else neg_total++;
                    for (int p = 0; p < NUM_CELLS; p++)
                        sym_count[p*6 + int'(label)*3 + sym_index(b[p])]++;
                    a.accepted = 1'b1;
                end
            end
            MODE_CLASSIFY: begin
                a.predicted = class_score(b, 1, pos_total, neg_total)
                              > class_score(b, 0, neg_total, pos_total);
                a.accepted = 1'b1;
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic send_request(logic [1:0] mode, t_board b, logic label, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        for (int p = 0; p < NUM_CELLS; p++) i_s_tdata[2*p +: 2] <= b[p];
        i_s_tdata[18] <= label;
        i_s_tdata[TDATA_IN_BITS-1:19] <= '0;
        do @(posedge i_clk); while (!o_s_tready);
        answer_q.push_back(predict_answer(mode, b, label));
    endtask

    function automatic t_board random_board();
        t_board b;
        foreach (b[p]) b[p] = 2'($urandom_range(0, 3));
        return b;
    endfunction

    // x-heavy boards lean positive, o-heavy negative, so both answers occur
    function automatic t_board biased_board(logic label);
        t_board b;
        foreach (b[p]) begin
            if ($urandom_range(0, 3) == 0) b[p] = 2'($urandom_range(0, 3));
            else b[p] = label ? 2'd1 : 2'd2;
        end
        return b;
    endfunction

    function automatic t_board flat_board(logic [1:0] code);
        t_board b;
        foreach (b[p]) b[p] = code;
        return b;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (answer_q.size() == 0) begin
                    $error("unexpected result tdata=%h", o_m_tdata);
                    fail_count++;
                end else begin
                    t_answer e;
                    e = answer_q.pop_front();
                    if (o_m_tdata[0] !== e.predicted) begin
                        $error("predicted_class expected %0d actual %0d",
                               e.predicted, o_m_tdata[0]);
                        fail_count++;
                    end
                    if (o_m_tdata[1] !== e.accepted) begin
                        $error("accepted expected %0d actual %0d", e.accepted, o_m_tdata[1]);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        int wait_cnt;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (1) begin
            if (hold_off > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold_off) @(posedge i_clk);
                hold_off = 0;
            end
            wait_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (wait_cnt > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_cnt) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    task automatic wait_drained();
        while (answer_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(MODE_CLASSIFY, flat_board(2'd0), 1'b0);
        send_request(MODE_NONE, flat_board(2'd3), 1'b1);
        send_request(MODE_TRAIN, flat_board(2'd1), 1'b1);
        send_request(MODE_CLASSIFY, flat_board(2'd1), 1'b0);
        send_request(MODE_TRAIN, flat_board(2'd2), 1'b0);
        send_request(MODE_TRAIN, flat_board(2'd3), 1'b1);
        send_request(MODE_TRAIN, flat_board(2'd0), 1'b0);
        send_request(MODE_CLASSIFY, flat_board(2'd1), 1'b1);
        send_request(MODE_CLASSIFY, flat_board(2'd2), 1'b0);
        send_request(MODE_CLASSIFY, flat_board(2'd3), 1'b0);
        send_request(MODE_CLASSIFY, flat_board(2'd0), 1'b0);
        send_request(MODE_CLEAR, flat_board(2'd3), 1'b1);
        send_request(MODE_TRAIN, flat_board(2'd2), 1'b0);
        send_request(MODE_CLASSIFY, flat_board(2'd2), 1'b0);
        send_request(MODE_NONE, random_board(), 1'b0);
        send_request(MODE_CLEAR, flat_board(2'd0), 1'b0);
    endtask

    task automatic test_random_mix();
        logic lbl;
        for (int n = 0; n < 180; n++) begin
            lbl = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 19))
                0:       send_request(MODE_CLEAR, random_board(), lbl);
                1:       send_request(MODE_NONE, random_board(), lbl);
                2, 3, 4: send_request(MODE_TRAIN, random_board(), lbl);
                5, 6, 7, 8, 9, 10, 11:
                         send_request(MODE_TRAIN, biased_board(lbl), lbl);
                default: send_request(MODE_CLASSIFY,
                             $urandom_range(0, 1) ? biased_board(lbl) : random_board(), lbl);
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_off = 600;
        for (int n = 0; n < 20; n++)
            send_request(n % 2 ? MODE_CLASSIFY : MODE_TRAIN, random_board(),
                         1'($urandom_range(0, 1)), 1);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        fail_count  = 0;
        hold_off    = 0;
        pos_total   = 0;
        neg_total   = 0;
        foreach (sym_count[k]) sym_count[k] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_mix();
        test_random_mix();
        i_s_tvalid <= 1'b0;

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && answer_q.size() == 0) begin
            $display("categorical_naive_bayes_classifier_tb: clean");
        end else begin
            $display("categorical_naive_bayes_classifier_tb: errors");
        end
        $finish;
    end

endmodule
